/* hdl/ffpa_pkg.sv */
package ffpa_pkg;

	// Sizing of the page map
	localparam int POOL_PAGES_MAX = 1024;
	localparam int PAGE_SHIFT     = 12;

	// Field widths
	localparam int CNT_W   = 11;
	localparam int BASE_W  = 20;
	localparam int ADDR_W  = 32;
	localparam int LIMIT_W = 64;

	// Map addressing and page arithmetic widths
	localparam int MAP_AW = (POOL_PAGES_MAX > 1) ? $clog2(POOL_PAGES_MAX) : 1;
	localparam int IDX_W  = $clog2(POOL_PAGES_MAX + 1);
	localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
	localparam int LPG_W  = ADDR_W - PAGE_SHIFT + 1;
	localparam int PN_W   = ((BASE_W > ADDR_W - PAGE_SHIFT) ? BASE_W : ADDR_W - PAGE_SHIFT) + 1;
	localparam int FA_W   = (ADDR_W > BASE_W + PAGE_SHIFT) ? ADDR_W : BASE_W + PAGE_SHIFT;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_PAGE_ONLY = 2'd2;

	// Operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;
	localparam logic [ADDR_W-1:0] ADDR32_MAX = '1;

endpackage

/* hdl/ffpa_if.sv */
// Request channel: one allocate or free per transaction
interface ffpa_req_if;
	import ffpa_pkg::*;
	logic                valid;
	logic                ready;
	logic                func;
	logic [CNT_W-1:0]    run_pages;
	logic [LIMIT_W-1:0]  addr_limit;
	logic [ADDR_W-1:0]   free_address;

	modport source(output valid, func, run_pages, addr_limit, free_address, input ready);
	modport sink(input valid, func, run_pages, addr_limit, free_address, output ready);
endinterface

// Response channel: one result per request
interface ffpa_rsp_if;
	import ffpa_pkg::*;
	logic               valid;
	logic               ready;
	logic               granted;
	logic [ADDR_W-1:0]  run_address;
	logic [CNT_W-1:0]   pages_in_use;
	logic [CNT_W-1:0]   peak_in_use;

	modport source(output valid, granted, run_address, pages_in_use, peak_in_use, input ready);
	modport sink(input valid, granted, run_address, pages_in_use, peak_in_use, output ready);
endinterface

// Register write channel
interface ffpa_cfg_if;
	import ffpa_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hdl/first_fit_frame_pool_allocator.sv */
// Allocate: accept, then scan the pages in order through the registered map read,
//   mark the first fitting run's pages, then load the result (failed checks skip
//   straight to the result). Free: clear the run's pages inside the pool, then load
//   the result. One request in flight at a time; the map's single write port and
//   registered read port set the per-page pace.
// Reset clears registers at once; a clearing pass over the whole map then zeroes it,
//   during which no request is taken (register writes are taken throughout).
module first_fit_frame_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	ffpa_req_if.sink    req,
	ffpa_rsp_if.source  rsp,
	ffpa_cfg_if.sink    cfg
);
	import ffpa_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [BASE_W-1:0] base_frame_q;
	logic [CNT_W-1:0]  pool_pages_q;
	logic              single_q;

	// request context
	logic              func_q;
	logic [CNT_W-1:0]  len_q;
	logic [PN_W-1:0]   limit_pg_q;
	logic              granted_q;
	logic [IDX_W-1:0]  first_q;

	// scan pipeline
	logic [IDX_W-1:0]  rd_idx_q;
	logic              chk_vld_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	logic [IDX_W-1:0]  run_q;

	// map write sequencing
	logic [MAP_AW-1:0] clr_idx_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic [CNT_W-1:0]  left_q;

	// counters
	logic [CNT_W-1:0]  in_use_q;
	logic [CNT_W-1:0]  peak_q;

	// output register
	logic              rsp_valid_q;
	logic              rsp_granted_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic [CNT_W-1:0]  rsp_use_q;
	logic [CNT_W-1:0]  rsp_peak_q;

	// map port
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr;
	logic              map_wdata;
	logic [MAP_AW-1:0] map_raddr;
	logic              map_rdata;

	logic [IDX_W-1:0]  n_pages;
	logic [IDX_W-1:0]  sum_op;
	logic [PN_W-1:0]   page_sum;
	logic [PN_W+PAGE_SHIFT-1:0] byte_addr;

	logic              req_acc;
	logic [ADDR_W-1:0] lim_eff;
	logic [ADDR_W:0]   lim_plus;
	logic              alloc_reject;
	logic [FA_W-1:0]   fa_ext;
	logic [FA_W-1:0]   pool_start;
	logic [FA_W-1:0]   first_pg;
	logic              free_in_pool;

	logic              page_bad;
	logic [IDX_W-1:0]  run_inc;
	logic              run_hit;
	logic              scan_last;
	logic              free_wr;
	logic              rsp_free;

	logic [CNT_W:0]    use_sum;
	logic [CNT_W-1:0]  use_nxt;
	logic [CNT_W-1:0]  peak_nxt;

	// effective pool size, clipped to the map
	assign n_pages = (CMP_W'(pool_pages_q) > CMP_W'(POOL_PAGES_MAX))
		? IDX_W'(POOL_PAGES_MAX) : IDX_W'(pool_pages_q);

	// shared page-number adder: scan check, then result address
	assign sum_op    = (state_q == ST_DONE) ? first_q : chk_idx_s1;
	assign page_sum  = PN_W'(base_frame_q) + PN_W'(sum_op);
	assign byte_addr = {page_sum, {PAGE_SHIFT{1'b0}}};

	// request decode
	assign req_acc  = req.valid && req.ready;
	assign lim_eff  = (|req.addr_limit[LIMIT_W-1:ADDR_W]) ? ADDR32_MAX
		: req.addr_limit[ADDR_W-1:0];
	assign lim_plus = {1'b0, lim_eff} + {{ADDR_W{1'b0}}, 1'b1};
	assign alloc_reject = (n_pages == '0) || (req.run_pages == '0)
		|| (single_q && (req.run_pages > CNT_W'(1)));
	assign fa_ext     = FA_W'(req.free_address);
	assign pool_start = FA_W'({base_frame_q, {PAGE_SHIFT{1'b0}}});
	assign first_pg   = (fa_ext - pool_start) >> PAGE_SHIFT;
	assign free_in_pool = (fa_ext >= pool_start) && (first_pg < FA_W'(n_pages));

	// scan evaluation on the page whose map bit has just been read
	assign page_bad  = map_rdata || (page_sum >= limit_pg_q);
	assign run_inc   = run_q + IDX_W'(1);
	assign run_hit   = !page_bad && (CMP_W'(run_inc) == CMP_W'(len_q));
	assign scan_last = (chk_idx_s1 == n_pages - IDX_W'(1));

	assign free_wr  = (state_q == ST_FREE) && (left_q != '0) && (wr_idx_q < n_pages);
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// map port control
	always_comb begin
		map_raddr = rd_idx_q[MAP_AW-1:0];
		map_we    = (state_q == ST_CLEAR) || (state_q == ST_MARK) || free_wr;
		map_wdata = (state_q == ST_MARK);
		map_waddr = (state_q == ST_CLEAR) ? clr_idx_q : wr_idx_q[MAP_AW-1:0];
	end

	// counter update for the finishing request
	always_comb begin
		use_sum = {1'b0, in_use_q} + {1'b0, len_q};
		if (func_q == FUNC_FREE) begin
			use_nxt = (len_q <= in_use_q) ? in_use_q - len_q : '0;
		end else if (granted_q) begin
			use_nxt = use_sum[CNT_W] ? COUNT_MAX : use_sum[CNT_W-1:0];
		end else begin
			use_nxt = in_use_q;
		end
		peak_nxt = (use_nxt > peak_q) ? use_nxt : peak_q;
	end

	ffpa_ram #(
		.WIDTH (1),
		.DEPTH (POOL_PAGES_MAX)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_frame_q <= '0;
			pool_pages_q <= '0;
			single_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BASE_FRAME:       base_frame_q <= cfg.data[BASE_W-1:0];
				CFG_POOL_PAGES:       pool_pages_q <= cfg.data[CNT_W-1:0];
				CFG_SINGLE_PAGE_ONLY: single_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			in_use_q    <= '0;
			peak_q      <= '0;
			rsp_valid_q <= 1'b0;
			chk_vld_s1  <= 1'b0;
		end else begin
			// result valid: set on finish, dropped once taken
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + MAP_AW'(1);
					if (clr_idx_q == MAP_AW'(POOL_PAGES_MAX - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (req_acc) begin
						func_q     <= req.func;
						len_q      <= req.run_pages;
						limit_pg_q <= PN_W'(lim_plus[ADDR_W:PAGE_SHIFT]);
						left_q     <= req.run_pages;
						wr_idx_q   <= IDX_W'(first_pg);
						rd_idx_q   <= '0;
						run_q      <= '0;
						chk_vld_s1 <= 1'b0;
						granted_q  <= (req.func == FUNC_FREE);
						first_q    <= '0;
						if (req.func == FUNC_FREE) begin
							state_q <= free_in_pool ? ST_FREE : ST_DONE;
						end else begin
							state_q <= alloc_reject ? ST_DONE : ST_SCAN;
						end
					end
				end

				ST_SCAN: begin
					// issue the next map read; stop the pipe once the scan ends
					chk_vld_s1 <= (rd_idx_q < n_pages)
						&& !(chk_vld_s1 && (run_hit || scan_last));
					chk_idx_s1 <= rd_idx_q;
					if (rd_idx_q < n_pages) begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
					// judge the page read last cycle
					if (chk_vld_s1) begin
						run_q <= page_bad ? '0 : run_inc;
						if (run_hit) begin
							first_q    <= IDX_W'(CMP_W'(chk_idx_s1) + CMP_W'(1) - CMP_W'(len_q));
							wr_idx_q   <= IDX_W'(CMP_W'(chk_idx_s1) + CMP_W'(1) - CMP_W'(len_q));
							granted_q  <= 1'b1;
							state_q    <= ST_MARK;
						end else if (scan_last) begin
							granted_q  <= 1'b0;
							state_q    <= ST_DONE;
						end
					end
				end

				ST_MARK: begin
					wr_idx_q <= wr_idx_q + IDX_W'(1);
					left_q   <= left_q - CNT_W'(1);
					if (left_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end

				ST_FREE: begin
					if (free_wr) begin
						wr_idx_q <= wr_idx_q + IDX_W'(1);
						left_q   <= left_q - CNT_W'(1);
					end else begin
						state_q <= ST_DONE;
					end
				end

				ST_DONE: begin
					if (rsp_free) begin
						rsp_granted_q <= granted_q;
						rsp_addr_q    <= (granted_q && func_q == FUNC_ALLOC)
							? byte_addr[ADDR_W-1:0] : '0;
						rsp_use_q     <= use_nxt;
						rsp_peak_q    <= peak_nxt;
						in_use_q      <= use_nxt;
						peak_q        <= peak_nxt;
						state_q       <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted      = rsp_granted_q;
	assign rsp.run_address  = rsp_addr_q;
	assign rsp.pages_in_use = rsp_use_q;
	assign rsp.peak_in_use  = rsp_peak_q;

endmodule

/* hdl/ffpa_ram.sv */
module ffpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/ffpa_checker.sv */
module ffpa_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_ready,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  logic                           rsp_granted,
	input  logic [ffpa_pkg::ADDR_W-1:0]    rsp_run_address,
	input  logic [ffpa_pkg::CNT_W-1:0]     rsp_pages_in_use,
	input  logic [ffpa_pkg::CNT_W-1:0]     rsp_peak_in_use
);
	import ffpa_pkg::*;

	// one request at a time: busy right after a transaction
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted)
			&& $stable(rsp_run_address) && $stable(rsp_pages_in_use))
		else $error("stalled result changed");

	// peak never below current use
	a_peak_ge_use: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_peak_in_use >= rsp_pages_in_use)
		else $error("peak below pages in use");

	// refused allocation reports no address
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_granted |-> rsp_run_address == '0)
		else $error("address on refused allocation");

endmodule

bind first_fit_frame_pool_allocator ffpa_checker u_ffpa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_granted      (rsp.granted),
	.rsp_run_address  (rsp.run_address),
	.rsp_pages_in_use (rsp.pages_in_use),
	.rsp_peak_in_use  (rsp.peak_in_use)
);

/* test/first_fit_frame_pool_allocator_tb.sv */
module first_fit_frame_pool_allocator_tb;
	import ffpa_pkg::*;

	localparam bit [63:0] PAGE_BYTES  = 64'd1 << PAGE_SHIFT;
	localparam bit [63:0] NO_LIMIT    = '1;
	// worst allocate is a full scan plus marking, plus stalls
	localparam int        STALL_LIMIT = 10000;
	localparam int        TAIL_CYCLES = 16;

	typedef struct packed {
		logic               func;
		logic [CNT_W-1:0]   run_pages;
		logic [LIMIT_W-1:0] addr_limit;
		logic [ADDR_W-1:0]  free_address;
	} pool_req_t;

	typedef struct packed {
		logic              granted;
		logic [ADDR_W-1:0] run_address;
		logic [CNT_W-1:0]  pages_in_use;
		logic [CNT_W-1:0]  peak_in_use;
	} pool_result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  pages;
	} live_run_t;

	logic clk;
	logic arst_n;

	ffpa_req_if req_ch();
	ffpa_rsp_if rsp_ch();
	ffpa_cfg_if cfg_ch();

	first_fit_frame_pool_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow of the block's registers and page map
	bit [BASE_W-1:0] shadow_base;
	bit [CNT_W-1:0]  shadow_pool;
	bit              shadow_single;
	bit              page_used [POOL_PAGES_MAX];
	int unsigned     in_use_pages;
	int unsigned     peak_pages;

	pool_result_t due_responses[$];
	live_run_t    live_runs[$];
	int           err_count;
	bit           idle_on = 1'b1;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit [63:0] pool_base_addr();
		bit [63:0] start;
		start = shadow_base;
		return start << PAGE_SHIFT;
	endfunction

	// Apply one transaction to the shadow page map and work out its response
	function automatic pool_result_t apply_pool_op(pool_req_t r);
		pool_result_t res;
		int unsigned  n;
		int unsigned  run;
		int unsigned  first;
		bit [63:0]    start;
		bit [63:0]    limit;
		bit [63:0]    last;
		bit [63:0]    first_page;
		bit [63:0]    addr64;
		res   = '0;
		n     = (shadow_pool > POOL_PAGES_MAX) ? POOL_PAGES_MAX : shadow_pool;
		start = pool_base_addr();
		if (r.func == FUNC_ALLOC) begin
			if (n != 0 && r.run_pages != 0 && !(shadow_single && r.run_pages > 1)) begin
				limit = (r.addr_limit > 64'(ADDR32_MAX)) ? 64'(ADDR32_MAX) : r.addr_limit;
				run   = 0;
				for (int i = 0; i < n; i++) begin
					last = start + 64'(i) * PAGE_BYTES + PAGE_BYTES - 1;
					if (page_used[i] || last > limit) begin
						run = 0;
					end else begin
						run++;
						if (run == r.run_pages) begin
							first = i + 1 - run;
							for (int j = first; j <= i; j++)
								page_used[j] = 1'b1;
							in_use_pages += r.run_pages;
							if (in_use_pages > COUNT_MAX)
								in_use_pages = COUNT_MAX;
							if (in_use_pages > peak_pages)
								peak_pages = in_use_pages;
							addr64          = start + 64'(first) * PAGE_BYTES;
							res.granted     = 1'b1;
							res.run_address = addr64[ADDR_W-1:0];
							break;
						end
					end
				end
			end
		end else begin
			// only pages inside the pool are cleared; count drops regardless
			if (64'(r.free_address) >= start) begin
				first_page = (64'(r.free_address) - start) >> PAGE_SHIFT;
				for (bit [63:0] p = first_page; p < first_page + r.run_pages && p < n; p++)
					page_used[p] = 1'b0;
			end
			in_use_pages -= (r.run_pages <= in_use_pages) ? r.run_pages : in_use_pages;
			res.granted = 1'b1;
		end
		res.pages_in_use = in_use_pages[CNT_W-1:0];
		res.peak_in_use  = peak_pages[CNT_W-1:0];
		return res;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endfunction

	// Response sink: random ready bursts while idling is on
	initial begin : response_sink
		int hold;
		hold         = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				rsp_ch.ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold         = $urandom_range(0, 11);
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	// Response check against the oldest outstanding prediction
	initial begin : response_check
		pool_result_t want;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (due_responses.size() == 0) begin
					$error("response transaction with no request outstanding");
					err_count++;
				end else begin
					want = due_responses.pop_front();
					check_field("granted", want.granted, rsp_ch.granted);
					check_field("run_address", want.run_address, rsp_ch.run_address);
					check_field("pages_in_use", want.pages_in_use, rsp_ch.pages_in_use);
					check_field("peak_in_use", want.peak_in_use, rsp_ch.peak_in_use);
				end
			end
		end
	end

	// Watchdog: cycles without any transaction on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			    (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
			    (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic req_pause(input int cycles);
		req_ch.valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (due_responses.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_BASE_FRAME:       shadow_base   = value[BASE_W-1:0];
			CFG_POOL_PAGES:       shadow_pool   = value[CNT_W-1:0];
			CFG_SINGLE_PAGE_ONLY: shadow_single = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Called at a falling edge; leaves valid high for a back-to-back transaction
	task automatic send_request(input pool_req_t r, output pool_result_t pred);
		req_ch.valid        = 1'b1;
		req_ch.func         = r.func;
		req_ch.run_pages    = r.run_pages;
		req_ch.addr_limit   = r.addr_limit;
		req_ch.free_address = r.free_address;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pred = apply_pool_op(r);
		due_responses.push_back(pred);
		@(negedge clk);
	endtask

	task automatic alloc_pages(input int pages, input logic [LIMIT_W-1:0] limit);
		pool_req_t    r;
		pool_result_t pred;
		r              = '0;
		r.func         = FUNC_ALLOC;
		r.run_pages    = CNT_W'(pages);
		r.addr_limit   = limit;
		r.free_address = {$urandom};
		send_request(r, pred);
		if (pred.granted)
			live_runs.push_back('{addr: pred.run_address, pages: CNT_W'(pages)});
	endtask

	task automatic free_pages(input logic [63:0] addr, input int pages);
		pool_req_t    r;
		pool_result_t pred;
		r              = '0;
		r.func         = FUNC_FREE;
		r.run_pages    = CNT_W'(pages);
		r.addr_limit   = {$urandom, $urandom};
		r.free_address = addr[ADDR_W-1:0];
		send_request(r, pred);
	endtask

	function automatic int pick_len(int unsigned pool);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return $urandom_range(1, 4);
		else if (sel < 85)
			return $urandom_range(1, 16);
		else if (sel < 97)
			return $urandom_range(1, (pool == 0) ? 1 : pool);
		else if (sel < 98)
			return 0;
		return POOL_PAGES_MAX;
	endfunction

	function automatic bit [63:0] pick_limit(int unsigned pool);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return NO_LIMIT;
		else if (sel < 70)
			return {$urandom, $urandom};
		return pool_base_addr() + $urandom_range(0, pool * PAGE_BYTES);
	endfunction

	// One configuration setting, swept clean, then mixed traffic
	task automatic run_phase(input int unsigned base, input int unsigned pool,
				 input bit single, input int count);
		int          sel;
		int          pick;
		live_run_t   victim;
		logic [31:0] addr;
		cfg_write(CFG_BASE_FRAME, base);
		cfg_write(CFG_POOL_PAGES, pool);
		cfg_write(CFG_SINGLE_PAGE_ONLY, single);
		free_pages(pool_base_addr(), POOL_PAGES_MAX);
		live_runs.delete();
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 49) == 0)
				wait_drained();
			if (idle_on && $urandom_range(0, 3) == 0)
				req_pause($urandom_range(1, 12));
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				alloc_pages(pick_len(pool), pick_limit(pool));
			end else if (sel < 88 && live_runs.size() != 0) begin
				pick   = $urandom_range(0, live_runs.size() - 1);
				victim = live_runs[pick];
				live_runs.delete(pick);
				addr   = victim.addr;
				if ($urandom_range(0, 3) == 0)
					addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
				free_pages(addr, victim.pages);
			end else if ($urandom_range(0, 1) == 0) begin
				// noise: free of an arbitrary address and length
				if ($urandom_range(0, 1) == 0)
					addr = $urandom;
				else
					addr = ADDR_W'(pool_base_addr() + $urandom_range(0, pool * PAGE_BYTES));
				free_pages(addr, $urandom_range(0, POOL_PAGES_MAX));
			end else begin
				alloc_pages($urandom_range(0, POOL_PAGES_MAX), {$urandom, $urandom});
			end
		end
	endtask

	// Absent pool: allocate fails, free still answers with counts held at zero
	task automatic test_pool_absent();
		cfg_write(CFG_BASE_FRAME, 0);
		cfg_write(CFG_POOL_PAGES, 0);
		alloc_pages(1, NO_LIMIT);
		free_pages(0, 1);
	endtask

	task automatic test_alloc_free_basics();
		bit [31:0] start;
		cfg_write(CFG_BASE_FRAME, 'h100);
		cfg_write(CFG_POOL_PAGES, 16);
		cfg_write(CFG_SINGLE_PAGE_ONLY, 0);
		start = ADDR_W'(pool_base_addr());
		alloc_pages(0, NO_LIMIT);
		alloc_pages(1, NO_LIMIT);
		alloc_pages(3, NO_LIMIT);
		alloc_pages(16, NO_LIMIT);
		// limit one byte short of page four's last byte
		alloc_pages(1, start + 4 * PAGE_BYTES + PAGE_BYTES - 2);
		// unaligned address clears the page that holds it
		free_pages(start + PAGE_BYTES + 123, 1);
		alloc_pages(1, NO_LIMIT);
		free_pages(start - 1, 2);
		free_pages(start + 14 * PAGE_BYTES, 5);
		free_pages(start, POOL_PAGES_MAX);
	endtask

	task automatic test_single_page_mode();
		cfg_write(CFG_SINGLE_PAGE_ONLY, 1);
		alloc_pages(2, NO_LIMIT);
		alloc_pages(1, NO_LIMIT);
		cfg_write(CFG_SINGLE_PAGE_ONLY, 0);
	endtask

	// Used bits past a lowered pool size survive a free of the whole pool
	task automatic test_shrunk_pool();
		alloc_pages(4, NO_LIMIT);
		cfg_write(CFG_POOL_PAGES, 2);
		free_pages(pool_base_addr(), 16);
		cfg_write(CFG_POOL_PAGES, 16);
		alloc_pages(3, NO_LIMIT);
		free_pages(pool_base_addr(), POOL_PAGES_MAX);
	endtask

	// Pool straddling the 4 GiB line: upper pages never handed out
	task automatic test_above_4gib();
		cfg_write(CFG_BASE_FRAME, 'hFFFF8);
		cfg_write(CFG_POOL_PAGES, 12);
		alloc_pages(8, NO_LIMIT);
		alloc_pages(1, NO_LIMIT);
		free_pages(pool_base_addr(), 8);
		cfg_write(CFG_BASE_FRAME, 'hFFFFF);
		cfg_write(CFG_POOL_PAGES, 1);
		alloc_pages(1, NO_LIMIT);
		free_pages(pool_base_addr(), 1);
	endtask

	// Pool size beyond the map is clamped to the map
	task automatic test_oversized_pool();
		cfg_write(CFG_BASE_FRAME, 0);
		cfg_write(CFG_POOL_PAGES, 2047);
		alloc_pages(POOL_PAGES_MAX, NO_LIMIT);
		free_pages(0, POOL_PAGES_MAX);
	endtask

	task automatic test_random_traffic();
		run_phase($urandom_range(0, 'hFFFFF - 1024), 64, 0, 170);
		run_phase('hFFFFF - 24, 48, 0, 80);
		run_phase(0, POOL_PAGES_MAX, 0, 40);
		run_phase($urandom_range(0, 'hFFFFF - 16), 16, 1, 60);
		// closing stretch runs without idling on either side
		wait_drained();
		idle_on = 1'b0;
		run_phase($urandom_range(0, 'hFFFFF), $urandom_range(1, 200), 0, 180);
	endtask

	initial begin : main_flow
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.func         = FUNC_ALLOC;
		req_ch.run_pages    = '0;
		req_ch.addr_limit   = '0;
		req_ch.free_address = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = CFG_BASE_FRAME;
		cfg_ch.data         = '0;
		err_count           = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_pool_absent();
		test_alloc_free_basics();
		test_single_page_mode();
		test_shrunk_pool();
		test_above_4gib();
		test_oversized_pool();
		test_random_traffic();

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (due_responses.size() != 0) begin
			$error("%0d response transactions never arrived", due_responses.size());
			err_count++;
		end
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
